// ----- src/bcrr_pkg.sv -----
// Shared types, constants and codes of the block cache round-robin controller.
package bcrr_pkg;

    // Number of cache slots held in the ring of cells.
    localparam int CACHE_SLOTS = 16;

    // Slot index width, kept at one bit for a single-slot ring.
    localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    // Width of a slot count that can hold CACHE_SLOTS itself.
    localparam int CNT_W = $clog2(CACHE_SLOTS + 1);

    localparam int TAG_W = 24;
    localparam int SIU_W = 7;
    localparam int BIF_W = 25;
    localparam int CFG_DATA_W = 25;
    localparam int STATUS_W = 3;
    localparam int OSLOT_W = 6;

    // Request modes.
    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RMISS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WMISS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BYPASS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLUSH_WB = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FLUSH_EMPTY = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_SLOTS_IN_USE = 1'b0;
    localparam logic CFG_BLOCKS_IN_FILE = 1'b1;

    // One request item.
    typedef struct packed {
        logic [1:0]       mode;
        logic [TAG_W-1:0] block_index;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OSLOT_W-1:0]  slot;
        logic                evict;
        logic [TAG_W-1:0]    evict_block;
        logic                last;
    } rsp_t;

    // Control from the sequencer to the ring of cells.
    typedef struct packed {
        logic             shift;
        logic             write;
        logic [TAG_W-1:0] tag;
    } ring_ctl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCAN,
        CS_DECIDE,
        CS_UPDATE,
        CS_FLUSH,
        CS_RESP
    } ctrl_state_t;

endpackage

// ----- src/block_cache_round_robin_controller.sv -----
// Top level of the block cache controller: configuration, ring of slot cells, sequencer.
//
// Usage. Requests enter on in_valid/in_stall/in_data (mode and block_index);
// an item is taken at a clock edge with in_valid high and in_stall low.
// Results leave on out_valid/out_stall/out_data from one output register.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while idle, which the block does not enforce:
// index 0 is slots_in_use, index 1 is blocks_in_file.
// Slot tags live in a ring of CACHE_SLOTS cells that rotates one slot per
// cycle past a single compare at the head. Path from acceptance to result:
//   out of range, bypass, flush with no active slot: straight to the result;
//   hit: one scan pass;
//   miss: a scan pass, then a pass to write the tag;
//   flush: one pass with one write-back per used slot, paused while stalled.
// One request is handled at a time; in_stall is high until its last result
// has been placed in the output register. A stall on the result side holds
// the output register and, during a flush, pauses the ring.
// Reset frees every slot, zeroes the victim pointer and restores
// slots_in_use to 16 and blocks_in_file to 0; no clearing pass is needed.
module block_cache_round_robin_controller
    import bcrr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsp_t                  out_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIU_W-1:0] siu_reg, siu_next;
    logic [BIF_W-1:0] bif_reg, bif_next;

    logic [TAG_W-1:0] cell_tag [CACHE_SLOTS];
    logic             cell_valid [CACHE_SLOTS];
    ring_ctl_t        ring;

    // Configuration register writes.
    always_comb
    begin
        siu_next = siu_reg;
        bif_next = bif_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLOTS_IN_USE: siu_next = cfg_data[SIU_W-1:0];
                CFG_BLOCKS_IN_FILE: bif_next = cfg_data[BIF_W-1:0];
                default: siu_next = siu_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg <= SIU_W'(16);
            bif_reg <= '0;
        end
        else
        begin
            siu_reg <= siu_next;
            bif_reg <= bif_next;
        end
    end

    // Ring of cells: each takes its upper neighbor, the last one takes the head
    // or, on a tag write, the new tag.
    for (genvar i = 0; i < CACHE_SLOTS; i++)
    begin : g_cell
        logic [TAG_W-1:0] src_tag;
        logic             src_valid;

        if (i == CACHE_SLOTS - 1)
        begin : g_wrap
            assign src_tag = ring.write ? ring.tag : cell_tag[0];
            assign src_valid = ring.write ? 1'b1 : cell_valid[0];
        end
        else
        begin : g_link
            assign src_tag = cell_tag[i + 1];
            assign src_valid = cell_valid[i + 1];
        end

        bcrr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (ring.shift),
            .in_tag   (src_tag),
            .in_valid (src_valid),
            .tag      (cell_tag[i]),
            .valid    (cell_valid[i])
        );
    end

    // Sequencer.
    bcrr_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .slots_in_use   (siu_reg),
        .blocks_in_file (bif_reg),
        .head_tag       (cell_tag[0]),
        .head_valid     (cell_valid[0]),
        .ring           (ring)
    );

endmodule

// ----- src/bcrr_cell.sv -----
// One slot cell of the tag ring: holds a tag and its valid bit.
module bcrr_cell
    import bcrr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [TAG_W-1:0] in_tag,
    input  logic             in_valid,
    output logic [TAG_W-1:0] tag,
    output logic             valid
);

    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    logic             valid_reg;
    logic             valid_next;

    // Take the neighbor's contents whenever the ring moves.
    always_comb
    begin
        tag_next = shift ? in_tag : tag_reg;
        valid_next = shift ? in_valid : valid_reg;
    end

    // The valid bit starts cleared so every slot is free after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The tag is only looked at while its valid bit is set.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag = tag_reg;
    assign valid = valid_reg;

endmodule

// ----- src/bcrr_ctrl.sv -----
// Sequencer of the block cache: scans the ring, picks the slot and forms results.
module bcrr_ctrl
    import bcrr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output rsp_t             out_data,
    input  logic [SIU_W-1:0] slots_in_use,
    input  logic [BIF_W-1:0] blocks_in_file,
    input  logic [TAG_W-1:0] head_tag,
    input  logic             head_valid,
    output ring_ctl_t        ring
);

    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(CACHE_SLOTS - 1);

    ctrl_state_t state_reg, state_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic [SLOT_W-1:0] vp_reg, vp_next;
    logic              hit_reg, hit_next;
    logic              fge_reg, fge_next;
    logic              flt_reg, flt_next;
    logic              pvalid_reg, pvalid_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    logic [1:0]        mode_reg, mode_next;
    logic [TAG_W-1:0]  blk_reg, blk_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0] p_reg, p_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0] fge_slot_reg, fge_slot_next;
    logic [SLOT_W-1:0] flt_slot_reg, flt_slot_next;
    logic [TAG_W-1:0]  ptag_reg, ptag_next;
    logic [SLOT_W-1:0] vict_reg, vict_next;
    rsp_t              res_reg, res_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]  pend_tag_reg, pend_tag_next;
    rsp_t              out_reg, out_next;

    logic [CNT_W-1:0]  n_cfg;
    logic [SLOT_W-1:0] p_cfg;
    logic              in_acc;
    logic              in_range;
    logic              head_act;
    logic              last_step;
    logic              out_free;
    logic              found;
    logic              flush_hold;
    logic              shift;
    logic              load_resp;
    logic              load_pend;
    logic [SLOT_W-1:0] ptr_inc;
    logic [STATUS_W-1:0] miss_status;

    // Active slot count and the pointer folded into that range.
    always_comb
    begin
        if (slots_in_use >= SIU_W'(CACHE_SLOTS))
        begin
            n_cfg = CNT_W'(CACHE_SLOTS);
        end
        else
        begin
            n_cfg = slots_in_use[CNT_W-1:0];
        end
        p_cfg = (CNT_W'(vp_reg) < n_cfg) ? vp_reg : '0;
    end

    // Handshake and ring movement.
    assign in_stall = (state_reg != CS_IDLE);
    assign in_acc = in_valid && (state_reg == CS_IDLE);
    assign in_range = ({1'b0, in_data.block_index} < blocks_in_file);
    assign head_act = (CNT_W'(step_reg) < n_reg);
    assign last_step = (step_reg == LAST_STEP);
    assign out_free = !out_valid_reg || !out_stall;
    assign found = head_act && head_valid;
    assign flush_hold = (state_reg == CS_FLUSH) && found && pend_valid_reg && !out_free;
    assign shift = (state_reg == CS_SCAN) || (state_reg == CS_UPDATE)
                   || ((state_reg == CS_FLUSH) && !flush_hold);
    assign load_resp = (state_reg == CS_RESP) && out_free;
    assign load_pend = (state_reg == CS_FLUSH) && shift && found && pend_valid_reg;
    assign ptr_inc = (CNT_W'(p_reg) + CNT_W'(1) == n_reg) ? '0 : p_reg + SLOT_W'(1);
    assign miss_status = (mode_reg == MODE_READ) ? ST_RMISS : ST_WMISS;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.mode == MODE_READ || in_data.mode == MODE_WRITE)
                    begin
                        state_next = (!in_range || n_cfg == '0) ? CS_RESP : CS_SCAN;
                    end
                    else if (in_data.mode == MODE_FLUSH)
                    begin
                        state_next = (n_cfg == '0) ? CS_RESP : CS_FLUSH;
                    end
                end
            end
            CS_SCAN:
            begin
                if (last_step)
                begin
                    state_next = CS_DECIDE;
                end
            end
            CS_DECIDE:
            begin
                state_next = hit_reg ? CS_RESP : CS_UPDATE;
            end
            CS_UPDATE:
            begin
                if (last_step)
                begin
                    state_next = CS_RESP;
                end
            end
            CS_FLUSH:
            begin
                if (shift && last_step)
                begin
                    state_next = CS_RESP;
                end
            end
            CS_RESP:
            begin
                if (out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs toward the ring and the result channel.
    always_comb
    begin
        ring.shift = shift;
        ring.write = (state_reg == CS_UPDATE) && (step_reg == vict_reg);
        ring.tag = blk_reg;
        out_valid = out_valid_reg;
        out_data = out_reg;
    end

    // Request capture, scan bookkeeping, victim choice and flush results.
    always_comb
    begin
        step_next = shift ? (last_step ? '0 : step_reg + SLOT_W'(1)) : step_reg;
        vp_next = vp_reg;
        hit_next = hit_reg;
        fge_next = fge_reg;
        flt_next = flt_reg;
        pvalid_next = pvalid_reg;
        pend_valid_next = pend_valid_reg;
        mode_next = mode_reg;
        blk_next = blk_reg;
        n_next = n_reg;
        p_next = p_reg;
        hit_slot_next = hit_slot_reg;
        fge_slot_next = fge_slot_reg;
        flt_slot_next = flt_slot_reg;
        ptag_next = ptag_reg;
        vict_next = vict_reg;
        res_next = res_reg;
        pend_slot_next = pend_slot_reg;
        pend_tag_next = pend_tag_reg;

        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next = in_data.mode;
                    blk_next = in_data.block_index;
                    n_next = n_cfg;
                    p_next = p_cfg;
                    hit_next = 1'b0;
                    fge_next = 1'b0;
                    flt_next = 1'b0;
                    pend_valid_next = 1'b0;
                    res_next = '{status: ST_BYPASS, slot: '0, evict: 1'b0,
                                 evict_block: '0, last: 1'b1};
                    if (in_data.mode == MODE_FLUSH)
                    begin
                        res_next.status = ST_FLUSH_EMPTY;
                    end
                    else if (!in_range)
                    begin
                        res_next.status = ST_RANGE;
                    end
                end
            end
            CS_SCAN:
            begin
                if (head_act)
                begin
                    // Lowest matching slot wins.
                    if (head_valid && head_tag == blk_reg && !hit_reg)
                    begin
                        hit_next = 1'b1;
                        hit_slot_next = step_reg;
                    end
                    // First free slot at or after the pointer, and first before it.
                    if (!head_valid && step_reg >= p_reg && !fge_reg)
                    begin
                        fge_next = 1'b1;
                        fge_slot_next = step_reg;
                    end
                    if (!head_valid && step_reg < p_reg && !flt_reg)
                    begin
                        flt_next = 1'b1;
                        flt_slot_next = step_reg;
                    end
                    if (step_reg == p_reg)
                    begin
                        ptag_next = head_tag;
                        pvalid_next = head_valid;
                    end
                end
            end
            CS_DECIDE:
            begin
                res_next = '{status: miss_status, slot: '0, evict: 1'b0,
                             evict_block: '0, last: 1'b1};
                priority if (hit_reg)
                begin
                    res_next.status = ST_HIT;
                    res_next.slot = OSLOT_W'(hit_slot_reg);
                end
                else if (!pvalid_reg)
                begin
                    vict_next = p_reg;
                    vp_next = ptr_inc;
                    res_next.slot = OSLOT_W'(p_reg);
                end
                else if (fge_reg)
                begin
                    vict_next = fge_slot_reg;
                    vp_next = p_reg;
                    res_next.slot = OSLOT_W'(fge_slot_reg);
                end
                else if (flt_reg)
                begin
                    vict_next = flt_slot_reg;
                    vp_next = p_reg;
                    res_next.slot = OSLOT_W'(flt_slot_reg);
                end
                else
                begin
                    // Every active slot is taken: write back the pointer's slot.
                    vict_next = p_reg;
                    vp_next = ptr_inc;
                    res_next.slot = OSLOT_W'(p_reg);
                    res_next.evict = 1'b1;
                    res_next.evict_block = ptag_reg;
                end
            end
            CS_UPDATE:
            begin
            end
            CS_FLUSH:
            begin
                // Each write-back is held until the next one is found, so the final one can be marked.
                if (shift && found)
                begin
                    pend_valid_next = 1'b1;
                    pend_slot_next = step_reg;
                    pend_tag_next = head_tag;
                end
                if (shift && last_step)
                begin
                    pend_valid_next = 1'b0;
                    res_next = '{status: ST_FLUSH_EMPTY, slot: '0, evict: 1'b0,
                                 evict_block: '0, last: 1'b1};
                    if (found)
                    begin
                        res_next.status = ST_FLUSH_WB;
                        res_next.slot = OSLOT_W'(step_reg);
                        res_next.evict = 1'b1;
                        res_next.evict_block = head_tag;
                    end
                    else if (pend_valid_reg)
                    begin
                        res_next.status = ST_FLUSH_WB;
                        res_next.slot = OSLOT_W'(pend_slot_reg);
                        res_next.evict = 1'b1;
                        res_next.evict_block = pend_tag_reg;
                    end
                end
            end
            CS_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register loads a finished result when the slot is free.
    always_comb
    begin
        out_next = out_reg;
        if (load_resp)
        begin
            out_next = res_reg;
        end
        else if (load_pend)
        begin
            out_next = '{status: ST_FLUSH_WB, slot: OSLOT_W'(pend_slot_reg), evict: 1'b1,
                         evict_block: pend_tag_reg, last: 1'b0};
        end
        if (load_resp || load_pend)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            step_reg <= '0;
            vp_reg <= '0;
            hit_reg <= 1'b0;
            fge_reg <= 1'b0;
            flt_reg <= 1'b0;
            pvalid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            vp_reg <= vp_next;
            hit_reg <= hit_next;
            fge_reg <= fge_next;
            flt_reg <= flt_next;
            pvalid_reg <= pvalid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        blk_reg <= blk_next;
        n_reg <= n_next;
        p_reg <= p_next;
        hit_slot_reg <= hit_slot_next;
        fge_slot_reg <= fge_slot_next;
        flt_slot_reg <= flt_slot_next;
        ptag_reg <= ptag_next;
        vict_reg <= vict_next;
        res_reg <= res_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg <= pend_tag_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // The ring is aligned (slot 0 at the head) whenever a request may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_IDLE |-> step_reg == '0)
        else $error("ring not aligned while idle");

    // Tags are replaced only during the update pass, on a moving ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        ring.write |-> (state_reg == CS_UPDATE) && ring.shift)
        else $error("tag write outside the update pass");

    // A hit never asks for a write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_HIT |-> !out_reg.evict)
        else $error("hit result carries an eviction");

    // A flush write-back always names its block for write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_FLUSH_WB |-> out_reg.evict)
        else $error("flush write-back without evict");

    // The pointer stays inside the slot range after each miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_UPDATE |-> CNT_W'(vp_reg) < n_reg)
        else $error("victim pointer beyond active slots");
`endif

endmodule

// ----- tb/block_cache_round_robin_controller_tb.sv -----
// Self-checking testbench for the block cache round-robin controller.
module block_cache_round_robin_controller_tb
    import bcrr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Mode value that the controller ignores.
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    // A miss makes two passes over the slots, the most of any request.
    localparam int SETTLE_CYCLES = 2 * CACHE_SLOTS + 40;
    localparam int PRINT_CAP = 50;
    localparam logic [BIF_W-1:0] ALL_BLOCKS = 25'd16777216;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    req_t                  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    rsp_t                  out_data;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = CFG_SLOTS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Requests waiting to be sent, and results the cache still owes.
    req_t queued_requests[$];
    rsp_t awaited_results[$];

    // Predicted cache state and register settings.
    logic [TAG_W-1:0] slot_block [CACHE_SLOTS];
    bit               slot_used  [CACHE_SLOTS];
    int               rr_next = 0;
    logic [SIU_W-1:0] active_limit = 7'd16;
    logic [BIF_W-1:0] blocks_limit = '0;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int request_count = 0;
    int result_count = 0;
    int hit_count = 0;
    int evict_count = 0;
    int writeback_count = 0;
    int setting_count = 0;
    rsp_t want;

    block_cache_round_robin_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard limit on the run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("[block_cache_round_robin_controller] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_CAP)
        begin
            $display("cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic rsp_t make_rsp(logic [STATUS_W-1:0] st, int slot, logic ev,
                                      logic [TAG_W-1:0] blk, logic lst);
        rsp_t r;
        r.status = st;
        r.slot = slot[OSLOT_W-1:0];
        r.evict = ev;
        r.evict_block = blk;
        r.last = lst;
        return r;
    endfunction

    function automatic int ring_next(int x, int n);
        return (x + 1 == n) ? 0 : x + 1;
    endfunction

    // Work out the results of one accepted request and update the predicted state.
    function automatic void cache_outcome(req_t req);
        int n;
        int i;
        int p;
        int t;
        int used_total;
        int k;
        logic [STATUS_W-1:0] miss_status;
        n = (active_limit < CACHE_SLOTS) ? int'(active_limit) : CACHE_SLOTS;
        if (req.mode == MODE_NONE)
        begin
            return;
        end
        request_count++;

        // A flush writes back every used active slot and keeps it valid.
        if (req.mode == MODE_FLUSH)
        begin
            used_total = 0;
            for (i = 0; i < n; i++)
            begin
                if (slot_used[i])
                begin
                    used_total++;
                end
            end
            if (used_total == 0)
            begin
                awaited_results.push_back(make_rsp(ST_FLUSH_EMPTY, 0, 1'b0, '0, 1'b1));
                return;
            end
            k = 0;
            for (i = 0; i < n; i++)
            begin
                if (slot_used[i])
                begin
                    k++;
                    writeback_count++;
                    awaited_results.push_back(make_rsp(ST_FLUSH_WB, i, 1'b1, slot_block[i],
                                                       k == used_total));
                end
            end
            return;
        end

        // The range check comes before the bypass.
        if ({1'b0, req.block_index} >= blocks_limit)
        begin
            awaited_results.push_back(make_rsp(ST_RANGE, 0, 1'b0, '0, 1'b1));
            return;
        end
        if (n == 0)
        begin
            awaited_results.push_back(make_rsp(ST_BYPASS, 0, 1'b0, '0, 1'b1));
            return;
        end

        // The lowest matching slot is the hit.
        for (i = 0; i < n; i++)
        begin
            if (slot_used[i] && slot_block[i] == req.block_index)
            begin
                hit_count++;
                awaited_results.push_back(make_rsp(ST_HIT, i, 1'b0, '0, 1'b1));
                return;
            end
        end

        // Miss: take a free slot from the pointer on, else evict the pointer's slot.
        miss_status = (req.mode == MODE_READ) ? ST_RMISS : ST_WMISS;
        p = (rr_next < n) ? rr_next : 0;
        if (!slot_used[p])
        begin
            rr_next = ring_next(p, n);
            t = p;
            awaited_results.push_back(make_rsp(miss_status, p, 1'b0, '0, 1'b1));
        end
        else
        begin
            t = ring_next(p, n);
            while (t != p && slot_used[t])
            begin
                t = ring_next(t, n);
            end
            if (t != p)
            begin
                rr_next = p;
                awaited_results.push_back(make_rsp(miss_status, t, 1'b0, '0, 1'b1));
            end
            else
            begin
                rr_next = ring_next(p, n);
                evict_count++;
                awaited_results.push_back(make_rsp(miss_status, p, 1'b1, slot_block[p],
                                                   1'b1));
            end
        end
        slot_block[t] = req.block_index;
        slot_used[t] = 1'b1;
    endfunction

    // Request driver: predicts each accepted item and presents the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cache_outcome(in_data);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    in_data <= queued_requests.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                    begin
                        send_gap = $urandom_range(1, 15);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted item and stalls in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with none awaited: %p", out_data));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.status !== want.status || out_data.slot !== want.slot ||
                        out_data.evict !== want.evict ||
                        out_data.evict_block !== want.evict_block ||
                        out_data.last !== want.last)
                    begin
                        report_mismatch($sformatf(
                            "got st %0d slot %0d ev %0d blk %h last %0d, want %0d %0d %0d %h %0d",
                            out_data.status, out_data.slot, out_data.evict,
                            out_data.evict_block, out_data.last, want.status, want.slot,
                            want.evict, want.evict_block, want.last));
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_request(logic [1:0] mode, logic [TAG_W-1:0] blk);
        req_t r;
        r.mode = mode;
        r.block_index = blk;
        queued_requests.push_back(r);
    endtask

    // Wait until every item is sent and answered, then let the block settle.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (queued_requests.size() != 0 || in_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLOTS_IN_USE)
        begin
            active_limit = value[SIU_W-1:0];
        end
        else
        begin
            blocks_limit = value[BIF_W-1:0];
        end
        setting_count++;
        @(negedge clk);
    endtask

    // Random traffic: mostly reads and writes over a small working set of blocks.
    task automatic queue_random(int count, int hot_n);
        logic [TAG_W-1:0] hot [24];
        logic [1:0]       mode;
        logic [TAG_W-1:0] blk;
        int               made;
        int               roll;
        int               pick;
        made = 0;
        for (int i = 0; i < hot_n; i++)
        begin
            hot[i] = (blocks_limit == 0) ? TAG_W'($urandom)
                                         : TAG_W'($urandom_range(0, blocks_limit - 1));
        end
        while (made < count)
        begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (roll < 5)
            begin
                mode = MODE_FLUSH;
            end
            else if (roll < 8)
            begin
                mode = MODE_NONE;
            end
            else
            begin
                mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
            end
            if (pick < 65)
            begin
                blk = hot[$urandom_range(0, hot_n - 1)];
            end
            else if (pick < 90 && blocks_limit != 0)
            begin
                blk = TAG_W'($urandom_range(0, blocks_limit - 1));
            end
            else if (pick < 97 && blocks_limit < ALL_BLOCKS)
            begin
                blk = TAG_W'($urandom_range(blocks_limit, 24'hFFFFFF));
            end
            else
            begin
                blk = TAG_W'($urandom);
            end
            queue_request(mode, blk);
            if (mode != MODE_NONE)
            begin
                made++;
            end
        end
    endtask

    task automatic run_phase(int slots, int blocks, int count, int hot_n, bit idle);
        wait_drained();
        write_register(CFG_SLOTS_IN_USE, CFG_DATA_W'(slots));
        write_register(CFG_BLOCKS_IN_FILE, CFG_DATA_W'(blocks));
        idle_on = idle;
        queue_random(count, hot_n);
    endtask

    // Stimulus: directed corner cases, then random phases over several settings.
    initial
    begin
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_block[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: no block is in range, and the cache starts empty.
        queue_request(MODE_READ, 24'd5);
        queue_request(MODE_WRITE, 24'hFFFFFF);
        queue_request(MODE_FLUSH, 24'd0);
        queue_request(MODE_NONE, 24'd0);
        wait_drained();

        // No active slots: in-range requests bypass the cache.
        write_register(CFG_BLOCKS_IN_FILE, ALL_BLOCKS);
        write_register(CFG_SLOTS_IN_USE, 25'd0);
        queue_request(MODE_READ, 24'hFFFFFF);
        queue_request(MODE_WRITE, 24'd0);
        queue_request(MODE_FLUSH, 24'hFFFFFF);
        wait_drained();

        // Two slots: fill, hit, evict, flush, and the range boundary.
        write_register(CFG_SLOTS_IN_USE, 25'd2);
        write_register(CFG_BLOCKS_IN_FILE, 25'd100);
        queue_request(MODE_READ, 24'd100);
        queue_request(MODE_READ, 24'd99);
        queue_request(MODE_WRITE, 24'd7);
        queue_request(MODE_READ, 24'd99);
        queue_request(MODE_WRITE, 24'd8);
        queue_request(MODE_FLUSH, 24'd0);
        queue_request(MODE_READ, 24'd7);
        wait_drained();

        // More slots requested than exist: free-slot search past a used pointer.
        write_register(CFG_SLOTS_IN_USE, 25'd64);
        queue_request(MODE_READ, 24'd99);
        queue_request(MODE_WRITE, 24'd0);
        queue_request(MODE_FLUSH, 24'd0);
        wait_drained();

        // One slot evicts the block in slot zero, leaving a duplicate above it.
        write_register(CFG_SLOTS_IN_USE, 25'd1);
        queue_request(MODE_READ, 24'd7);
        wait_drained();
        write_register(CFG_SLOTS_IN_USE, 25'd16);
        queue_request(MODE_READ, 24'd7);

        run_phase(16, ALL_BLOCKS, 70, 24, 1'b1);
        run_phase(4, 1000, 60, 8, 1'b1);
        run_phase(1, 1, 25, 2, 1'b1);
        run_phase(2, 16777215, 40, 6, 1'b0);
        run_phase(64, $urandom_range(17, ALL_BLOCKS), 60, 20, 1'b1);
        run_phase(0, $urandom_range(1, ALL_BLOCKS), 30, 8, 1'b1);
        run_phase($urandom_range(0, 64), $urandom_range(0, ALL_BLOCKS), 50, 16, 1'b1);
        run_phase(16, ALL_BLOCKS, 60, 12, 1'b0);
        wait_drained();

        $display("Ran %0d requests giving %0d results across %0d register writes,",
                 request_count, result_count, setting_count);
        $display("including %0d hits, %0d evictions and %0d flush write-backs.",
                 hit_count, evict_count, writeback_count);
        if (error_count == 0)
        begin
            $display("[block_cache_round_robin_controller] OK");
        end
        else
        begin
            $display("[block_cache_round_robin_controller] ERROR");
        end
        $finish;
    end

endmodule

// ----- block_cache_round_robin_controller.f -----
src/bcrr_pkg.sv
src/bcrr_cell.sv
src/bcrr_ctrl.sv
src/block_cache_round_robin_controller.sv
tb/block_cache_round_robin_controller_tb.sv
